@@ design/spq_pkg.sv @@
// shared constants, codes and types for the sorted priority queue
package spq_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ID_W    = 16;
   localparam int PRIO_W  = 16;
   localparam int STAT_W  = 2;
   localparam int HELD_W  = 5;
   localparam int REQ_W   = ID_W + PRIO_W;
   localparam int RSP_W   = 40;

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic enq;
      logic deq;
   } spq_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_HOLD = 2'b10
   } spq_state_type;

endpackage

@@ design/spq_ctrl.sv @@
// controller: request acceptance and response holding state machine
module spq_ctrl
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_cmd,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output spq_cmd_type cmd
);

   spq_state_type state_ff, state_in;
   logic          accept;

   always_comb begin
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: req_tready = 1'b1;
         S_HOLD: req_tready = rsp_tready;
         default: req_tready = 1'b0;
      endcase
   end

   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_HOLD);
   assign cmd.enq    = accept && (req_cmd == CMD_ENQ);
   assign cmd.deq    = accept && (req_cmd == CMD_DEQ);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            state_in = S_HOLD;
         end
         S_HOLD: if (rsp_tready && !accept) begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/spq_datapath.sv @@
// datapath: sorted shift-register cells, entry count and response registers
module spq_datapath
   import spq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  spq_cmd_type       cmd,
   input  logic [ID_W-1:0]   job_id,
   input  logic [PRIO_W-1:0] job_priority,
   output logic [STAT_W-1:0] status,
   output logic [ID_W-1:0]   head_id,
   output logic [PRIO_W-1:0] head_priority,
   output logic [HELD_W-1:0] held_count
);

   logic [ID_W-1:0]   id_ff [DEPTH];
   logic [ID_W-1:0]   id_in [DEPTH];
   logic [PRIO_W-1:0] pr_ff [DEPTH];
   logic [PRIO_W-1:0] pr_in [DEPTH];
   logic [DEPTH-1:0]  gt;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]   head_id_ff, head_id_in;
   logic [PRIO_W-1:0] head_pr_ff, head_pr_in;
   logic [CNT_W-1:0]  held_ff;
   logic [31:0]       held_ext;
   logic              full, empty, do_enq, do_deq;

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign do_enq = cmd.enq && !full;
   assign do_deq = cmd.deq && !empty;

   // every live cell compares against the new priority at once
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && ($signed(pr_ff[i]) > $signed(job_priority));
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         id_in[i] = id_ff[i];
         pr_in[i] = pr_ff[i];
         if (do_enq) begin
            if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
               id_in[i] = id_ff[(i > 0) ? i - 1 : 0];
               pr_in[i] = pr_ff[(i > 0) ? i - 1 : 0];
            end else if (gt[i] || CNT_W'(i) == count_ff) begin
               id_in[i] = job_id;
               pr_in[i] = job_priority;
            end
         end else if (do_deq && i < DEPTH - 1) begin
            id_in[i] = id_ff[(i < DEPTH - 1) ? i + 1 : i];
            pr_in[i] = pr_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      count_in   = count_ff;
      status_in  = ST_DONE;
      head_id_in = '0;
      head_pr_in = '0;
      if (do_enq) begin
         count_in = count_ff + 1'b1;
      end else if (do_deq) begin
         count_in   = count_ff - 1'b1;
         head_id_in = id_ff[0];
         head_pr_in = pr_ff[0];
      end else if (cmd.enq) begin
         status_in = ST_FULL;
      end else if (cmd.deq) begin
         status_in = ST_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         id_ff[i] <= id_in[i];
         pr_ff[i] <= pr_in[i];
      end
      if (cmd.enq || cmd.deq) begin
         status_ff  <= status_in;
         head_id_ff <= head_id_in;
         head_pr_ff <= head_pr_in;
         held_ff    <= count_in;
      end
   end

   // count reported modulo 32
   assign held_ext      = 32'(held_ff);
   assign status        = status_ff;
   assign head_id       = head_id_ff;
   assign head_priority = head_pr_ff;
   assign held_count    = held_ext[HELD_W-1:0];

endmodule

@@ design/sorted_priority_queue.sv @@
// top level of the sorted priority queue
//
// channel  direction  payload
// req      in         tuser: cmd; tdata: job_id, job_priority
// rsp      out        tuser: status; tdata: head_id, head_priority, held_count
//
// one request per cycle unless rsp stalls; each is sorted into the cell row when accepted
// the response is registered and appears the cycle after acceptance
// a stalled response holds off new requests; one is taken as the old response is taken
// synchronous reset empties the queue; cell contents are not cleared
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // job_id, job_priority
   input  logic [0:0]       req_tuser,   // cmd
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // head_id, head_priority, held_count, zero pad
   output logic [STAT_W-1:0] rsp_tuser   // status
);

   spq_cmd_type       cmd;
   logic [ID_W-1:0]   head_id;
   logic [PRIO_W-1:0] head_priority;
   logic [HELD_W-1:0] held_count;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   spq_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .job_id        (req_tdata[ID_W-1:0]),
      .job_priority  (req_tdata[REQ_W-1:ID_W]),
      .status        (rsp_tuser),
      .head_id       (head_id),
      .head_priority (head_priority),
      .held_count    (held_count)
   );

   assign rsp_tdata = {{(RSP_W - ID_W - PRIO_W - HELD_W){1'b0}},
                       held_count, head_priority, head_id};

endmodule

@@ design/spq_checker.sv @@
// port checker for the sorted priority queue, bound to the top level
module spq_checker
   import spq_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic [0:0]       req_tuser,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic [STAT_W-1:0] rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_DONE |-> rsp_tdata[ID_W+PRIO_W-1:0] == '0)
      else $error("refused request returned a head entry");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL
      |-> rsp_tdata[ID_W+PRIO_W+HELD_W-1:ID_W+PRIO_W] == HELD_W'(DEPTH))
      else $error("full refusal with wrong count");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_EMPTY
      |-> rsp_tdata[ID_W+PRIO_W+HELD_W-1:ID_W+PRIO_W] == '0)
      else $error("empty refusal with nonzero count");

   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request gave no response");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
